>>> rtl/btng_pkg.sv
// shared types and constants of the beep tone / noise generator
// no dependencies; imported by the controller, datapath and top level
`timescale 1ns / 1ps

package btng_pkg;

  // item kinds carried in the operation field
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_BEEP   = 2'd1,
    OP_ENABLE = 2'd2,
    OP_STOP   = 2'd3
  } op_t;

  // field widths
  localparam int FREQ_W  = 14;
  localparam int DUR_W   = 12;
  localparam int HZ_W    = 13;   // saturated frequency, 0..8000
  localparam int MS_W    = 11;   // saturated duration, 1..2000
  localparam int RATE_W  = 17;   // sample rate up to 96000
  localparam int RQ_W    = 7;    // rate / 1000, up to 96
  localparam int RR_W    = 10;   // rate % 1000
  localparam int MR_W    = MS_W + RR_W;   // ms * (rate % 1000)
  localparam int NSUM_W  = 18;   // ms * rate / 1000, up to 192000
  localparam int FRAC_W  = 11;   // ms * (rate % 1000) / 1000, up to 1998
  localparam int RECIP_W = 20;
  localparam int RP_W    = MR_W + RECIP_W;
  localparam int RECIP_SH = 29;
  localparam int LEFT_W  = 17;
  localparam int PER_W   = 12;
  localparam int LFSR_W  = 16;
  localparam int SAMP_W  = 16;
  localparam int CNT_W   = 5;    // divider step counter

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  localparam int MS_PER_S = 1000;

  // limits and constants
  localparam logic [HZ_W-1:0]   MAX_HZ     = 13'd8000;
  localparam logic [HZ_W-1:0]   MIN_DIV_HZ = 13'd20;
  localparam logic [MS_W-1:0]   MAX_MS     = 11'd2000;
  localparam logic [MS_W-1:0]   MIN_MS     = 11'd1;
  // ceil(2^29 / 1000): exact floor division by 1000 for any 21-bit value
  localparam logic [RECIP_W-1:0] RECIP_1000 = 20'd536871;
  localparam logic [LEFT_W-1:0] MAX_LEFT   = 17'h1FFFF;
  localparam logic [PER_W-1:0]  MAX_PERIOD = 12'd4095;
  localparam logic [PER_W-1:0]  MIN_PERIOD = 12'd2;
  localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_RST   = 16'h0001;
  localparam logic signed [SAMP_W-1:0] AMP = 16'sd22000;
  localparam logic [CNT_W-1:0]  DIV_STEPS  = 5'(RATE_W);

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // input transfer this cycle
    logic mul;        // register duration times rate quotient and remainder
    logic recip;      // register remainder product / 1000
    logic store_n;    // write sample count, reset phase, set mode
    logic load_p;     // start divider on rate / frequency
    logic store_p;    // write tone period
    logic step;       // one divider step
    logic out_load;   // move result into the output register
  } btng_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    op_t  op;         // operation of the offered item
    logic hz_zero;    // latched beep asks for noise
    logic div_done;   // divider idle
  } btng_sts_t;

endpackage

>>> rtl/btng_ctrl.sv
// controller state machine of the beep tone / noise generator
// depends on btng_pkg; drives btng_dp through command and status structs
`timescale 1ns / 1ps

module btng_ctrl
  import btng_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  btng_sts_t sts,
  output btng_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_MUL,
    S_RECIP,
    S_STORE_N,
    S_LOAD_P,
    S_DIV_P
  } state_t;

  state_t state;
  state_t state_next;
  logic   m_tvalid_next;

  assign s_tready = (state == S_IDLE);

  // command decode and next state
  always_comb begin
    cmd           = '0;
    state_next    = state;
    m_tvalid_next = m_tvalid && !m_tready;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          unique case (sts.op)
            OP_TICK:   state_next = S_EMIT;
            OP_BEEP:   state_next = S_MUL;
            OP_ENABLE: state_next = S_IDLE;
            OP_STOP:   state_next = S_IDLE;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_EMIT: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_RECIP;
      end
      S_RECIP: begin
        cmd.recip  = 1'b1;
        state_next = S_STORE_N;
      end
      S_STORE_N: begin
        cmd.store_n = 1'b1;
        state_next  = sts.hz_zero ? S_IDLE : S_LOAD_P;
      end
      S_LOAD_P: begin
        cmd.load_p = 1'b1;
        state_next = S_DIV_P;
      end
      S_DIV_P: begin
        cmd.step = 1'b1;
        if (sts.div_done) begin
          cmd.store_p = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

>>> rtl/btng_dp.sv
// datapath of the beep tone / noise generator: playback state, tick
// sample logic, sample count setup, restoring divider and output register; uses btng_pkg
`timescale 1ns / 1ps

module btng_dp
  import btng_pkg::*;
#(
  parameter int SAMPLE_RATE = 44100
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  btng_cmd_t             cmd,
  output btng_sts_t             sts
);

  localparam logic [RATE_W-1:0] RATE_V   = RATE_W'(SAMPLE_RATE);
  localparam logic [RQ_W-1:0]   RATE_Q_V = RQ_W'(SAMPLE_RATE / MS_PER_S);
  localparam logic [RR_W-1:0]   RATE_R_V = RR_W'(SAMPLE_RATE % MS_PER_S);

  // input fields
  logic [1:0]        in_op;
  logic [FREQ_W-1:0] in_freq;
  logic [DUR_W-1:0]  in_dur;
  logic              in_en;

  assign in_op   = s_tdata[1:0];
  assign in_freq = s_tdata[15:2];
  assign in_dur  = s_tdata[27:16];
  assign in_en   = s_tdata[28];

  // playback state
  logic              sound_enabled;
  logic [LEFT_W-1:0] samples_left;
  logic [PER_W-1:0]  phase_count;
  logic [PER_W-1:0]  period_len;
  logic              noise_mode;
  logic [LFSR_W-1:0] noise_lfsr;

  // beep setup registers
  logic [HZ_W-1:0]   hz_sat;
  logic [MS_W-1:0]   ms_sat;
  logic              hz_zero;
  logic [NSUM_W-1:0] n_base;
  logic [MR_W-1:0]   ms_rem;
  logic [FRAC_W-1:0] n_frac;

  // divider
  logic [RATE_W-1:0] quo;
  logic [HZ_W-1:0]   rem;
  logic [HZ_W-1:0]   divisor;
  logic [CNT_W-1:0]  div_cnt;
  logic [HZ_W:0]     partial;
  logic              q_bit;

  // result registers
  logic signed [SAMP_W-1:0] res_sample;
  logic                     res_playing;
  logic signed [SAMP_W-1:0] out_sample;
  logic                     out_playing;

  assign sts.op       = op_t'(in_op);
  assign sts.hz_zero  = hz_zero;
  assign sts.div_done = (div_cnt == '0);

  // saturation of the beep fields
  logic [HZ_W-1:0] hz_in_sat;
  logic [MS_W-1:0] ms_in_sat;
  always_comb begin
    hz_in_sat = (in_freq > FREQ_W'(MAX_HZ)) ? MAX_HZ : in_freq[HZ_W-1:0];
    if (in_dur == '0)
      ms_in_sat = MIN_MS;
    else if (in_dur > DUR_W'(MAX_MS))
      ms_in_sat = MAX_MS;
    else
      ms_in_sat = in_dur[MS_W-1:0];
  end

  // tick evaluation
  logic              tick_run;
  logic [PER_W-1:0]  p_eff;
  logic [PER_W-1:0]  ph;
  logic [PER_W-1:0]  ph_inc;
  logic [PER_W-1:0]  ph_new;
  logic              tone_hi;
  logic [LFSR_W-1:0] lfsr_new;
  logic [LEFT_W-1:0] left_dec;
  always_comb begin
    tick_run = sound_enabled && (samples_left != '0);
    p_eff    = (period_len < MIN_PERIOD) ? MIN_PERIOD : period_len;
    ph       = (phase_count >= p_eff) ? '0 : phase_count;
    tone_hi  = (ph < (p_eff >> 1));
    ph_inc   = ph + PER_W'(1);
    ph_new   = (ph_inc >= p_eff) ? '0 : ph_inc;
    lfsr_new = (noise_lfsr >> 1) ^ (noise_lfsr[0] ? LFSR_TAPS : '0);
    left_dec = samples_left - LEFT_W'(1);
  end

  // sample count: ms * (rate / 1000) + (ms * (rate % 1000)) / 1000,
  // the division by 1000 done as a reciprocal multiply
  logic [RP_W-1:0]   recip_prod;
  logic [NSUM_W-1:0] n_sum;
  logic [LEFT_W-1:0] n_sat;
  always_comb begin
    recip_prod = RP_W'(ms_rem) * RP_W'(RECIP_1000);
    n_sum      = n_base + NSUM_W'(n_frac);
    n_sat      = (n_sum > NSUM_W'(MAX_LEFT)) ? MAX_LEFT : n_sum[LEFT_W-1:0];
  end

  // divider step
  always_comb begin
    partial = {rem, quo[RATE_W-1]};
    q_bit   = (partial >= {1'b0, divisor});
  end

  // period saturation
  logic [PER_W-1:0]  p_sat;
  always_comb begin
    if (quo < RATE_W'(MIN_PERIOD))
      p_sat = MIN_PERIOD;
    else if (quo > RATE_W'(MAX_PERIOD))
      p_sat = MAX_PERIOD;
    else
      p_sat = quo[PER_W-1:0];
  end

  // playback state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sound_enabled <= 1'b1;
      samples_left  <= '0;
      phase_count   <= '0;
      period_len    <= '0;
      noise_mode    <= 1'b0;
      noise_lfsr    <= LFSR_RST;
    end else begin
      if (cmd.accept) begin
        unique case (op_t'(in_op))
          OP_TICK: begin
            if (tick_run) begin
              samples_left <= left_dec;
              if (noise_mode)
                noise_lfsr <= lfsr_new;
              else
                phase_count <= ph_new;
            end
          end
          OP_ENABLE: begin
            sound_enabled <= in_en;
            if (!in_en)
              samples_left <= '0;
          end
          OP_STOP:  samples_left <= '0;
          OP_BEEP:  ;
          default:  ;
        endcase
      end
      if (cmd.store_n) begin
        samples_left <= n_sat;
        phase_count  <= '0;
        if (hz_zero) begin
          noise_mode <= 1'b1;
          noise_lfsr <= LFSR_SEED;
          period_len <= MIN_PERIOD;
        end else begin
          noise_mode <= 1'b0;
        end
      end
      if (cmd.store_p)
        period_len <= p_sat;
    end
  end

  // divider control counter
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.load_p) begin
      div_cnt <= DIV_STEPS;
    end else if (cmd.step && div_cnt != '0) begin
      div_cnt <= div_cnt - CNT_W'(1);
    end
  end

  // beep setup and divider payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hz_sat  <= hz_in_sat;
      ms_sat  <= ms_in_sat;
      hz_zero <= (hz_in_sat == '0);
    end
    if (cmd.mul) begin
      n_base <= NSUM_W'(ms_sat) * NSUM_W'(RATE_Q_V);
      ms_rem <= MR_W'(ms_sat) * MR_W'(RATE_R_V);
    end
    if (cmd.recip)
      n_frac <= recip_prod[RECIP_SH +: FRAC_W];
    if (cmd.load_p) begin
      quo     <= RATE_V;
      rem     <= '0;
      divisor <= (hz_sat < MIN_DIV_HZ) ? MIN_DIV_HZ : hz_sat;
    end else if (cmd.step && div_cnt != '0) begin
      quo <= {quo[RATE_W-2:0], q_bit};
      rem <= q_bit ? HZ_W'(partial - {1'b0, divisor}) : partial[HZ_W-1:0];
    end
  end

  // tick result and output register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (tick_run) begin
        if (noise_mode)
          res_sample <= noise_lfsr[0] ? AMP : -AMP;
        else
          res_sample <= tone_hi ? AMP : -AMP;
        res_playing <= (left_dec != '0);
      end else begin
        res_sample  <= '0;
        res_playing <= (samples_left != '0);
      end
    end
    if (cmd.out_load) begin
      out_sample  <= res_sample;
      out_playing <= res_playing;
    end
  end

  assign m_tdata = {7'b0, out_playing, out_sample};

endmodule

>>> rtl/beep_tone_noise_generator.sv
// Beep tone / noise generator, top level: btng_ctrl and btng_dp
// depends on btng_pkg
//
// Usage:
//   Slave stream takes items: a sample tick, a beep request, a sound enable
//   write or a stop. Only a tick makes a transfer on the master stream
//   (one signed sample and a still-playing flag).
//   A tick is accepted, then the result is moved into the output register
//   and m_tvalid rises once that register is free. Enable and stop finish
//   on acceptance. A beep request runs a multiply, a reciprocal multiply
//   for the division by 1000 and a load of the sample count, then, for a
//   tone, a 17-step restoring divider for rate / frequency.
//   The input side takes a new item while a result waits in the output
//   register; a following tick is computed and then held until the
//   receiver takes the waiting result, so a stalled receiver stops input
//   after one tick.
//   Reset: sound enabled, nothing playing, output empty, LFSR at 1.
`timescale 1ns / 1ps

module beep_tone_noise_generator
  import btng_pkg::*;
#(
  parameter int SAMPLE_RATE = 44100
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // operation[1:0], req_freq[15:2], duration_ms[27:16], enable_value[28]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // sample[15:0] signed, still_playing[16]
  output logic [OUT_DATA_W-1:0] m_tdata
);

  btng_cmd_t cmd;
  btng_sts_t sts;

  // sequencing
  btng_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // state, divider and output register
  btng_dp #(
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule

>>> rtl/btng_chk.sv
// port checker of the beep tone / noise generator, bound to the top level
// depends on btng_pkg for widths
`timescale 1ns / 1ps

module btng_chk
  import btng_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // samples are silence or full amplitude
  a_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] == 16'd0 || m_tdata[15:0] == 16'd22000 ||
                  m_tdata[15:0] == 16'hAA10))
    else $error("sample out of set");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:17] == 7'd0))
    else $error("nonzero padding");

  // output empty after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result after reset");

  // ticks and beeps need further work after their transfer, so ready drops
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata[1:0] == OP_TICK || s_tdata[1:0] == OP_BEEP)
    |=> !s_tready)
    else $error("ready right after tick or beep transfer");

endmodule

bind beep_tone_noise_generator btng_chk u_btng_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
